// ----- rtl/core/sha256_byte_stream_hasher_assert.svh -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_assert.svh
// Assertion macros for the SHA-256 byte-stream hasher. They use the clock clk
// and the active-low reset arst_n of the including module.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Condition must never hold at a clock edge.
`define SBH_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SBH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/sha_bsh_pkg.sv -----
// ----------------------------------------------------------------------------
// sha_bsh_pkg
// Types, beat structs and SHA-256 constants shared by the byte-stream hasher.
// ----------------------------------------------------------------------------
package sha_bsh_pkg;

	localparam int unsigned BLOCK_BYTES  = 64;
	localparam int unsigned ROUNDS       = 64;
	localparam int unsigned LEN_POS      = 56;
	localparam int unsigned DIGEST_WORDS = 8;
	localparam logic [7:0]  PAD_BYTE     = 8'h80;

	typedef logic [31:0]      word_t;
	typedef logic [7:0][31:0] hash_t;   // index 0 is the least significant word

	// Input beat
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_valid;
		logic       end_of_message;
	} msg_beat_t;

	// Output beat
	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} dig_beat_t;

	// Commands to the message schedule / block buffer
	typedef struct packed {
		logic        shift_byte;
		logic        shift_len;
		logic        step;
		logic [7:0]  data;
		logic [63:0] len;
	} sched_ctl_t;

	// Commands to the round unit
	typedef struct packed {
		logic       init;
		logic       load;
		logic       step;
		logic       fold;
		logic [5:0] rnd;
	} round_ctl_t;

	// Initial hash value, word 0 in the low slot
	localparam hash_t HASH_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

	// Round constants
	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

endpackage

// ----- rtl/core/sha_bsh_sched.sv -----
// ----------------------------------------------------------------------------
// sha_bsh_sched
// Block buffer and message schedule in one 512-bit shift register. Bytes and
// the length field shift in from the bottom; during the rounds the window
// shifts one word per cycle and appends the next schedule word.
// ----------------------------------------------------------------------------
module sha_bsh_sched
	import sha_bsh_pkg::*;
(
	input  logic       clk,
	input  sched_ctl_t ctl,
	output word_t      w_t
);

	localparam int unsigned WIN_BITS = BLOCK_BYTES * 8;

	logic [WIN_BITS-1:0] win_q;
	word_t               w_next;

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	// Top word is W[t]; word 14 is W[t+1], word 6 W[t+9], word 1 W[t+14]
	assign w_t = win_q[32*15 +: 32];

	always_comb begin
		w_next = small_sigma1(win_q[32*1 +: 32]) + win_q[32*6 +: 32]
			+ small_sigma0(win_q[32*14 +: 32]) + win_q[32*15 +: 32];
	end

	// Payload only, no reset
	always_ff @(posedge clk) begin
		if (ctl.shift_byte) begin
			win_q <= {win_q[WIN_BITS-9:0], ctl.data};
		end else if (ctl.shift_len) begin
			win_q <= {win_q[WIN_BITS-65:0], ctl.len};
		end else if (ctl.step) begin
			win_q <= {win_q[WIN_BITS-33:0], w_next};
		end
	end

endmodule

// ----- rtl/core/sha_bsh_round.sv -----
// ----------------------------------------------------------------------------
// sha_bsh_round
// Shared SHA-256 round unit: working variables a..h updated one round per
// cycle, plus the chaining hash words with their feed-forward add.
// ----------------------------------------------------------------------------
module sha_bsh_round
	import sha_bsh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  round_ctl_t ctl,
	input  word_t      w_t,
	output hash_t      hash
);

	hash_t hash_q;
	hash_t v_q;     // v_q[0] = a ... v_q[7] = h
	word_t bs0, bs1, ch, mj, t1;

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	assign hash = hash_q;

	// One round of the compression function
	always_comb begin
		bs1 = big_sigma1(v_q[4]);
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1  = v_q[7] + bs1 + ch + ROUND_K[ctl.rnd] + w_t;
		bs0 = big_sigma0(v_q[0]);
		mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	end

	// Chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_IV;
		end else if (ctl.init) begin
			hash_q <= HASH_IV;
		end else if (ctl.fold) begin
			for (int i = 0; i < DIGEST_WORDS; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	// Working variables
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= hash_q;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + bs0 + mj;
		end
	end

endmodule

// ----- rtl/core/sha256_byte_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one shared round unit under a small sequencer.
//
// Input channel msg (msg_valid/msg_ready): one beat carries one message byte
// (byte_valid) and/or the end mark (end_of_message). A beat with neither is
// dropped. Output channel dig (dig_valid/dig_ready): eight beats per message,
// digest words 0..7, last_word set on word 7.
// The 64th byte of a block starts the compression: a load, 64 rounds and a
// feed-forward, with the single round unit doing one round per cycle;
// msg_ready is low meanwhile. An end beat with n bytes in the block pads one
// byte per cycle (0x80, then zeros up to byte 56), adds the length and
// compresses; for n of 56 or more the padding spills into a second block.
// An end beat that carries the 64th byte first compresses the full block.
// The first digest beat is registered after the last fold; further words
// follow one per cycle while dig_ready is high. A stalled receiver holds the
// digest beat and the block takes no input until the last word is taken;
// then the hash state returns to the initial value. Reset clears control
// state and the hash.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher
	import sha_bsh_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      msg_valid,
	output logic      msg_ready,
	input  msg_beat_t msg,
	output logic      dig_valid,
	input  logic      dig_ready,
	output dig_beat_t dig
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_LOAD,
		S_ROUND,
		S_FOLD,
		S_OUT
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [60:0] byte_cnt_q;
	logic        fin_q;
	logic        mark_q;
	logic        len_done_q;
	logic [5:0]  rnd_q;
	logic [2:0]  idx_q;
	logic        dig_valid_q;
	dig_beat_t   dig_q;

	logic        msg_take;
	logic        dig_take;
	logic        len_pos;
	logic        block_full;
	sched_ctl_t  sched_ctl;
	round_ctl_t  round_ctl;
	word_t       w_t;
	hash_t       hash;

	assign msg_ready = (state_q == S_IDLE);
	assign msg_take  = msg_valid && msg_ready;
	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;
	assign dig_take  = dig_valid_q && dig_ready;

	// Padding position checks
	assign len_pos    = mark_q && (fill_q == 6'(LEN_POS));
	assign block_full = (fill_q == 6'(BLOCK_BYTES - 1));

	// Datapath commands
	always_comb begin
		sched_ctl.shift_byte = (msg_take && msg.byte_valid)
			|| (state_q == S_PAD && !len_pos);
		sched_ctl.shift_len  = (state_q == S_PAD) && len_pos;
		sched_ctl.step       = (state_q == S_ROUND);
		sched_ctl.data       = (state_q == S_IDLE) ? msg.msg_byte
			: (mark_q ? 8'h00 : PAD_BYTE);
		sched_ctl.len        = {byte_cnt_q, 3'b000};

		round_ctl.init = (state_q == S_OUT) && dig_take && dig_q.last_word;
		round_ctl.load = (state_q == S_LOAD);
		round_ctl.step = (state_q == S_ROUND);
		round_ctl.fold = (state_q == S_FOLD);
		round_ctl.rnd  = rnd_q;
	end

	sha_bsh_sched u_sched (
		.clk (clk),
		.ctl (sched_ctl),
		.w_t (w_t)
	);

	sha_bsh_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (round_ctl),
		.w_t    (w_t),
		.hash   (hash)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			byte_cnt_q  <= '0;
			fin_q       <= 1'b0;
			mark_q      <= 1'b0;
			len_done_q  <= 1'b0;
			rnd_q       <= '0;
			idx_q       <= '0;
			dig_valid_q <= 1'b0;
			dig_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (msg_take) begin
						fin_q <= msg.end_of_message;
						if (msg.byte_valid) begin
							byte_cnt_q <= byte_cnt_q + 61'd1;
							fill_q     <= fill_q + 6'd1;
						end
						if (msg.byte_valid && block_full) begin
							state_q <= S_LOAD;
						end else if (msg.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (len_pos) begin
						fill_q     <= '0;
						len_done_q <= 1'b1;
						state_q    <= S_LOAD;
					end else begin
						mark_q <= 1'b1;
						fill_q <= fill_q + 6'd1;
						if (block_full) begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					rnd_q   <= '0;
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= S_FOLD;
					end
				end
				S_FOLD: begin
					if (len_done_q) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end else if (fin_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (dig_take && dig_q.last_word) begin
						dig_valid_q <= 1'b0;
						fin_q       <= 1'b0;
						mark_q      <= 1'b0;
						len_done_q  <= 1'b0;
						byte_cnt_q  <= '0;
						fill_q      <= '0;
						state_q     <= S_IDLE;
					end else if (!dig_valid_q || dig_ready) begin
						dig_q.digest_word <= hash[idx_q];
						dig_q.word_index  <= idx_q;
						dig_q.last_word   <= (idx_q == 3'(DIGEST_WORDS - 1));
						dig_valid_q       <= 1'b1;
						idx_q             <= idx_q + 3'd1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks
	`SBH_ASSERT_NEVER(a_no_input_during_digest, msg_ready && dig_valid,
		"input open while digest pending")
	`SBH_ASSERT_NEXT(a_last_word_frees_input, dig_valid && dig_ready && dig.last_word,
		msg_ready, "no return to idle after last digest word")
	`SBH_ASSERT_NEXT(a_full_block_compresses, msg_take && msg.byte_valid && block_full,
		state_q == S_LOAD, "full block did not start compression")
	`SBH_ASSERT_NEXT(a_rounds_end_in_fold, state_q == S_ROUND && rnd_q == 6'(ROUNDS - 1),
		state_q == S_FOLD, "round count overrun")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// SHA-256 byte-stream hasher testbench
// Drives byte beats over the msg channel and checks every digest beat against
// a cycle-free SHA-256 predictor running alongside, or a known digest. A short
// table of directed beats comes first (empty message, "abc", byte extremes,
// end with and without a byte, dropped beats). Random messages follow, with
// lengths near the padding spill and block boundary. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import sha_bsh_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned DRAIN_WAIT  = 250;
	localparam int unsigned ITEM_TARGET = 280;
	localparam int unsigned CALM_AFTER  = 240;
	localparam int unsigned DIR_ROWS    = 16;

	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	// One row of the directed table; typed_ok marks a digest known by heart
	typedef struct packed {
		msg_beat_t    beat;
		logic         typed_ok;
		logic [255:0] typed;
	} dir_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      msg_valid = 1'b0;
	logic      msg_ready;
	msg_beat_t msg       = '0;
	logic      dig_valid;
	logic      dig_ready = 1'b0;
	dig_beat_t dig;

	// Predictor state
	logic [31:0] pred_hash [8];
	logic [7:0]  pred_block [64];
	int unsigned fill_cnt;
	logic [63:0] len_bits;

	dig_beat_t   pending_words [$];
	dir_row_t    directed_rows [DIR_ROWS];
	int unsigned errors    = 0;
	int unsigned idle_cnt  = 0;
	bit          calm      = 1'b0;
	bit          hold_req  = 1'b0;

	sha256_byte_stream_hasher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function void restart_hash();
		for (int i = 0; i < 8; i++)
			pred_hash[i] = HASH_IV[i];
		fill_cnt = 0;
		len_bits = '0;
	endfunction

	// One 64-round compression of pred_block into pred_hash
	function void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, ch, mj, t1;
		for (int i = 0; i < 16; i++)
			w[i] = {pred_block[4*i], pred_block[4*i+1], pred_block[4*i+2], pred_block[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++)
			v[i] = pred_hash[i];
		for (int i = 0; i < 64; i++) begin
			s1 = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + s1 + ch + ROUND_K[i] + w[i];
			s0 = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + s0 + mj;
		end
		for (int i = 0; i < 8; i++)
			pred_hash[i] = pred_hash[i] + v[i];
	endfunction

	// Absorb one accepted beat; on an end beat, pad and queue the digest words
	function void absorb_msg_beat(msg_beat_t b, bit typed_ok, logic [255:0] typed);
		logic [63:0] total;
		dig_beat_t   r;
		if (b.byte_valid) begin
			pred_block[fill_cnt] = b.msg_byte;
			fill_cnt = fill_cnt + 1;
			if (fill_cnt == BLOCK_BYTES) begin
				compress_block();
				len_bits = len_bits + 64'd512;
				fill_cnt = 0;
			end
		end
		if (!b.end_of_message)
			return;
		total = len_bits + 64'(fill_cnt) * 64'd8;
		pred_block[fill_cnt] = PAD_BYTE;
		fill_cnt = fill_cnt + 1;
		// padding spills into a second block
		if (fill_cnt > LEN_POS) begin
			while (fill_cnt < BLOCK_BYTES) begin
				pred_block[fill_cnt] = 8'h00;
				fill_cnt = fill_cnt + 1;
			end
			compress_block();
			fill_cnt = 0;
		end
		while (fill_cnt < LEN_POS) begin
			pred_block[fill_cnt] = 8'h00;
			fill_cnt = fill_cnt + 1;
		end
		for (int i = 0; i < 8; i++)
			pred_block[LEN_POS + i] = total[63 - 8*i -: 8];
		compress_block();
		for (int i = 0; i < DIGEST_WORDS; i++) begin
			r.digest_word = typed_ok ? typed[255 - 32*i -: 32] : pred_hash[i];
			r.word_index  = 3'(i);
			r.last_word   = (i == DIGEST_WORDS - 1);
			pending_words.push_back(r);
		end
		restart_hash();
	endfunction

	// Offer one beat, with an optional random gap first; predict on acceptance
	task automatic offer_beat(input msg_beat_t b, input bit typed_ok,
			input logic [255:0] typed);
		if (!calm && $urandom_range(0, 3) == 0) begin
			msg_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		msg       <= b;
		msg_valid <= 1'b1;
		@(posedge clk);
		while (!msg_ready)
			@(posedge clk);
		absorb_msg_beat(b, typed_ok, typed);
	endtask

	// Receiver: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				dig_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				dig_ready <= 1'b1;
			end else if (!calm && arst_n && $urandom_range(0, 4) == 0) begin
				dig_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				dig_ready <= 1'b1;
			end else begin
				dig_ready <= 1'b1;
			end
		end
	end

	// Digest beat checker
	always @(posedge clk) begin
		dig_beat_t exp_beat;
		if (arst_n && dig_valid && dig_ready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected digest beat %h idx %0d last %0d",
					$time, dig.digest_word, dig.word_index, dig.last_word);
				errors++;
			end else begin
				exp_beat = pending_words.pop_front();
				if (dig.digest_word !== exp_beat.digest_word) begin
					$display("%0t: digest_word expected %h actual %h",
						$time, exp_beat.digest_word, dig.digest_word);
					errors++;
				end
				if (dig.word_index !== exp_beat.word_index) begin
					$display("%0t: word_index expected %0d actual %0d",
						$time, exp_beat.word_index, dig.word_index);
					errors++;
				end
				if (dig.last_word !== exp_beat.last_word) begin
					$display("%0t: last_word expected %0d actual %0d",
						$time, exp_beat.last_word, dig.last_word);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no beat moving on either channel
	always @(posedge clk) begin
		if ((msg_valid && msg_ready) || (dig_valid && dig_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt == STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int unsigned items;
		int unsigned msg_idx;
		int unsigned len;
		bit          end_on_byte;
		msg_beat_t   b;

		restart_hash();
		directed_rows = '{
			dir_row_t'{msg_beat_t'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
			dir_row_t'{msg_beat_t'{8'hff, 1'b0, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h00, 1'b0, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
			dir_row_t'{msg_beat_t'{8'h00, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h80, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h7f, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h55, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'haa, 1'b1, 1'b0}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h01, 1'b0, 1'b1}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'hff, 1'b1, 1'b1}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'h00, 1'b1, 1'b1}, 1'b0, 256'h0},
			dir_row_t'{msg_beat_t'{8'hff, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST}
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_ROWS; i++)
			offer_beat(directed_rows[i].beat, directed_rows[i].typed_ok,
				directed_rows[i].typed);
		items = DIR_ROWS;

		// random messages
		msg_idx = 0;
		while (items < ITEM_TARGET) begin
			// near the padding spill, then around a full block, then mostly short
			if (msg_idx == 0)
				len = $urandom_range(55, 57);
			else if (msg_idx == 1)
				len = $urandom_range(63, 65);
			else if ($urandom_range(0, 5) == 0)
				len = $urandom_range(50, 70);
			else
				len = $urandom_range(0, 12);

			// receiver holds off while the next message goes in
			if (msg_idx == 2)
				hold_req = 1'b1;
			// sender waits for every digest word to come back
			if (msg_idx == 4) begin
				msg_valid <= 1'b0;
				while (pending_words.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end

			end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
			for (int j = 0; j < len; j++) begin
				if ($urandom_range(0, 9) == 0) begin
					b.msg_byte       = 8'($urandom_range(0, 255));
					b.byte_valid     = 1'b0;
					b.end_of_message = 1'b0;
					offer_beat(b, 1'b0, 256'h0);
				end
				b.msg_byte       = 8'($urandom_range(0, 255));
				b.byte_valid     = 1'b1;
				b.end_of_message = end_on_byte && (j == len - 1);
				offer_beat(b, 1'b0, 256'h0);
				items++;
			end
			if (!end_on_byte) begin
				b.msg_byte       = 8'($urandom_range(0, 255));
				b.byte_valid     = 1'b0;
				b.end_of_message = 1'b1;
				offer_beat(b, 1'b0, 256'h0);
				items++;
			end
			msg_idx++;
			calm = (items > CALM_AFTER);
		end
		msg_valid <= 1'b0;

		// drain, then watch for stray beats
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (errors == 0 && pending_words.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
